>>> hw/rtl/flsc_pkg.sv
package flsc_pkg;

	// operation codes of an input item
	typedef enum logic [2:0] {
		OP_START = 3'd0,
		OP_POLL  = 3'd1,
		OP_MSG   = 3'd2,
		OP_PUT   = 3'd3,
		OP_QUERY = 3'd4
	} op_t;

	// link states
	typedef enum logic [1:0] {
		LINK_WAITING = 2'd0,
		LINK_OPEN    = 2'd1,
		LINK_ERROR   = 2'd2
	} link_t;

	// received message kinds, anything above fail is malformed
	localparam logic [1:0] MSG_LENT = 2'd0;
	localparam logic [1:0] MSG_FAIL = 2'd1;

	// error codes, sink fail reasons map to reason + 1
	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_MALFORMED  = 3'd5;
	localparam logic [2:0] ERR_UNRESOLVED = 3'd6;
	localparam logic [2:0] ERR_TIMEOUT    = 3'd7;

	// configuration register indexes
	localparam logic [1:0] CFG_DURATION = 2'd0;
	localparam logic [1:0] CFG_MAX_BUF  = 2'd1;
	localparam logic [1:0] CFG_RETRY    = 2'd2;
	localparam logic [1:0] CFG_GIVE_UP  = 2'd3;

	// values used when a register holds zero, also the reset values
	localparam logic [15:0] DFLT_DURATION = 16'd16;
	localparam logic [7:0]  DFLT_MAX_BUF  = 8'd16;
	localparam logic [15:0] DFLT_RETRY    = 16'd10;
	localparam logic [15:0] DFLT_GIVE_UP  = 16'd500;

	// one quotient bit per divider step
	localparam int DIV_STEPS = 32;

	typedef struct packed {
		logic capture;
		logic update;
		logic prep;
		logic div_step;
		logic load;
	} flsc_cmd_t;

endpackage

>>> hw/rtl/flsc_ctrl.sv
module flsc_ctrl import flsc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	output flsc_cmd_t cmd
);

	localparam int CNT_W = $clog2(DIV_STEPS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_UPDATE,
		S_PREP,
		S_DIV,
		S_DONE
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		cmd          = '0;
		cmd.capture  = (state_q == S_IDLE) && in_valid;
		cmd.update   = (state_q == S_UPDATE);
		cmd.prep     = (state_q == S_PREP);
		cmd.div_step = (state_q == S_DIV);
		cmd.load     = (state_q == S_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && !cmd.load)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					state_q <= S_PREP;
				end
				S_PREP: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST)
						state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> hw/rtl/flsc_dp.sv
module flsc_dp import flsc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  flsc_cmd_t          cmd,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_wdata,
	input  logic [2:0]         operation,
	input  logic [31:0]        now_ms,
	input  logic               resolve_ok,
	input  logic [1:0]         msg_kind,
	input  logic [1:0]         fail_reason,
	input  logic               send_ok,
	output logic [1:0]         link_state,
	output logic [2:0]         error_code,
	output logic               send_borrow,
	output logic               put_accepted,
	output logic [7:0]         frame_index,
	output logic [15:0]        ready_count,
	output logic signed [16:0] wait_ms
);

	// configuration
	logic [15:0] dur_cfg_q, retry_cfg_q, give_up_cfg_q;
	logic [7:0]  max_cfg_q;
	logic [15:0] dur_eff, retry_eff, give_up_eff;
	logic [7:0]  max_eff;

	// captured item
	logic [2:0]  op_q;
	logic [31:0] now_q;
	logic        resolve_q, send_q;
	logic [1:0]  kind_q, reason_q;

	// session state
	link_t       conn_q;
	logic [2:0]  fault_q;
	logic [31:0] first_req_q, last_req_q, stamp_q;
	logic        no_frame_q;
	logic [7:0]  next_idx_q;

	// per-item results and divider
	logic              borrow_q, accepted_q;
	logic [7:0]        index_q;
	logic [16:0]       wait_q;
	logic [15:0]       rem_q;
	logic [31:0]       quo_q;
	logic              lag_neg_q;

	logic [31:0] lag, since_first, since_last;
	logic [16:0] wait_now;
	logic        timed_out, retry_due;
	logic [23:0] backdate;
	logic [16:0] shifted, diff;
	logic [15:0] ready_next;

	assign dur_eff     = (dur_cfg_q == '0) ? DFLT_DURATION : dur_cfg_q;
	assign max_eff     = (max_cfg_q == '0) ? DFLT_MAX_BUF : max_cfg_q;
	assign retry_eff   = (retry_cfg_q == '0) ? DFLT_RETRY : retry_cfg_q;
	assign give_up_eff = (give_up_cfg_q == '0) ? DFLT_GIVE_UP : give_up_cfg_q;

	assign lag         = now_q - stamp_q;
	assign since_first = now_q - first_req_q;
	assign since_last  = now_q - last_req_q;
	assign timed_out   = !since_first[31] && (since_first > {16'd0, give_up_eff});
	assign retry_due   = !since_last[31] && (since_last > {16'd0, retry_eff});
	assign backdate    = 24'(max_eff - 8'd1) * 24'(dur_eff);

	// wait before the next put, from the state as it stands
	always_comb begin
		if (conn_q != LINK_OPEN)
			wait_now = '1;
		else if (no_frame_q || (lag > {16'd0, dur_eff}))
			wait_now = '0;
		else
			wait_now = {1'b0, dur_eff - lag[15:0]};
	end

	// restoring division step
	assign shifted = {1'b0, rem_q} << 1 | {16'd0, quo_q[31]};
	assign diff    = shifted - {1'b0, dur_eff};

	always_comb begin
		if (conn_q != LINK_OPEN)
			ready_next = '0;
		else if (no_frame_q)
			ready_next = {8'd0, max_eff};
		else if (lag_neg_q)
			ready_next = '0;
		else if (quo_q[31:16] != '0)
			ready_next = '1;
		else
			ready_next = quo_q[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dur_cfg_q     <= DFLT_DURATION;
			max_cfg_q     <= DFLT_MAX_BUF;
			retry_cfg_q   <= DFLT_RETRY;
			give_up_cfg_q <= DFLT_GIVE_UP;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DURATION: dur_cfg_q     <= cfg_wdata;
				CFG_MAX_BUF:  max_cfg_q     <= cfg_wdata[7:0];
				CFG_RETRY:    retry_cfg_q   <= cfg_wdata;
				CFG_GIVE_UP:  give_up_cfg_q <= cfg_wdata;
				default:      dur_cfg_q     <= dur_cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conn_q      <= LINK_WAITING;
			fault_q     <= ERR_NONE;
			first_req_q <= '0;
			last_req_q  <= '0;
			stamp_q     <= '0;
			no_frame_q  <= 1'b1;
			next_idx_q  <= '0;
		end else if (cmd.update) begin
			case (op_q)
				OP_START: begin
					next_idx_q <= '0;
					no_frame_q <= 1'b1;
					stamp_q    <= '0;
					if (resolve_q) begin
						conn_q      <= LINK_WAITING;
						fault_q     <= ERR_NONE;
						first_req_q <= now_q;
						last_req_q  <= now_q;
					end else begin
						conn_q  <= LINK_ERROR;
						fault_q <= ERR_UNRESOLVED;
					end
				end
				OP_POLL: begin
					if (conn_q == LINK_WAITING) begin
						if (timed_out) begin
							conn_q  <= LINK_ERROR;
							fault_q <= ERR_TIMEOUT;
						end else if (retry_due) begin
							last_req_q <= now_q;
						end
					end
				end
				OP_MSG: begin
					if (kind_q == MSG_LENT) begin
						conn_q     <= LINK_OPEN;
						no_frame_q <= 1'b1;
					end else if (kind_q == MSG_FAIL) begin
						conn_q  <= LINK_ERROR;
						fault_q <= {1'b0, reason_q} + 3'd1;
					end else begin
						conn_q  <= LINK_ERROR;
						fault_q <= ERR_MALFORMED;
					end
				end
				OP_PUT: begin
					if (conn_q == LINK_OPEN && send_q) begin
						next_idx_q <= next_idx_q + 8'd1;
						no_frame_q <= 1'b0;
						if (no_frame_q)
							stamp_q <= now_q - {8'd0, backdate};
						else
							stamp_q <= stamp_q + {16'd0, dur_eff};
					end
				end
				default: begin
					conn_q <= conn_q;
				end
			endcase
		end
	end

	// item capture and per-item results
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q      <= operation;
			now_q     <= now_ms;
			resolve_q <= resolve_ok;
			kind_q    <= msg_kind;
			reason_q  <= fail_reason;
			send_q    <= send_ok;
		end
		if (cmd.update) begin
			borrow_q   <= (op_q == OP_START && resolve_q) ||
			              (op_q == OP_POLL && conn_q == LINK_WAITING &&
			               !timed_out && retry_due);
			accepted_q <= (op_q == OP_PUT) && (conn_q == LINK_OPEN) && send_q;
			index_q    <= (op_q == OP_START) ? 8'd0 : next_idx_q;
			if (op_q == OP_PUT)
				wait_q <= wait_now;
		end
		if (cmd.prep) begin
			if (op_q != OP_PUT)
				wait_q <= wait_now;
			rem_q     <= '0;
			quo_q     <= lag;
			lag_neg_q <= lag[31];
		end
		if (cmd.div_step) begin
			if (!diff[16]) begin
				rem_q <= diff[15:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted[15:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
		if (cmd.load) begin
			link_state   <= conn_q;
			error_code   <= (conn_q == LINK_ERROR) ? fault_q : ERR_NONE;
			send_borrow  <= borrow_q;
			put_accepted <= accepted_q;
			frame_index  <= index_q;
			ready_count  <= ready_next;
			wait_ms      <= $signed(wait_q);
		end
	end

endmodule

>>> hw/rtl/frame_link_session_controller.sv
// frame link session controller, source side
// an input transfer passes through state update, lag setup, the 32-step
// serial divider for the ready count and the output load to its result
// a new item is taken only once the previous result has been loaded
// reset: arst_n low clears the session to waiting, registers to their defaults
module frame_link_session_controller import flsc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// configuration writes
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_wdata,
	// input item
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         operation,
	input  logic [31:0]        now_ms,
	input  logic               resolve_ok,
	input  logic [1:0]         msg_kind,
	input  logic [1:0]         fail_reason,
	input  logic               send_ok,
	// result item
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         link_state,
	output logic [2:0]         error_code,
	output logic               send_borrow,
	output logic               put_accepted,
	output logic [7:0]         frame_index,
	output logic [15:0]        ready_count,
	output logic signed [16:0] wait_ms
);

	// sequencing: capture, state update, lag setup, divide, load output
	flsc_cmd_t cmd;

	// the controller owns the handshakes; the result register lets a new
	// input transfer start while the previous result is still stalled
	flsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// session state, configuration, frame clock and ready count divider
	flsc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.operation    (operation),
		.now_ms       (now_ms),
		.resolve_ok   (resolve_ok),
		.msg_kind     (msg_kind),
		.fail_reason  (fail_reason),
		.send_ok      (send_ok),
		.link_state   (link_state),
		.error_code   (error_code),
		.send_borrow  (send_borrow),
		.put_accepted (put_accepted),
		.frame_index  (frame_index),
		.ready_count  (ready_count),
		.wait_ms      (wait_ms)
	);

endmodule

>>> tb/tb_frame_link_session_controller.sv
module tb_frame_link_session_controller;
	import flsc_pkg::*;

	// operation codes past query, the block only reports status on them
	localparam logic [2:0] OP_SPARE_LO = 3'd5;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;
	// message kinds above fail, both read as malformed
	localparam logic [1:0] MSG_JUNK_LO = 2'd2;
	localparam logic [1:0] MSG_JUNK_HI = 2'd3;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 40;
	localparam int MAX_GAP = 48;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] now;
		logic        resolve_ok;
		logic [1:0]  msg_kind;
		logic [1:0]  fail_reason;
		logic        send_ok;
	} link_item_t;

	typedef struct packed {
		link_t              link_state;
		logic [2:0]         error_code;
		logic               send_borrow;
		logic               put_accepted;
		logic [7:0]         frame_index;
		logic [15:0]        ready_count;
		logic signed [16:0] wait_ms;
	} link_result_t;

	// session predictor plus the queue of results still owed by the block
	class link_session_scoreboard;
		logic [15:0] duration_reg, retry_reg, give_up_reg;
		logic [7:0]  max_buf_reg;
		link_t       state;
		logic [2:0]  fault;
		logic [31:0] first_req, last_req, frame_stamp;
		bit          no_frame;
		logic [7:0]  next_idx;
		link_result_t due_results[$];
		int errors;
		int checked;

		function new();
			duration_reg = DFLT_DURATION;
			max_buf_reg = DFLT_MAX_BUF;
			retry_reg = DFLT_RETRY;
			give_up_reg = DFLT_GIVE_UP;
			state = LINK_WAITING;
			fault = ERR_NONE;
			first_req = '0;
			last_req = '0;
			frame_stamp = '0;
			no_frame = 1'b1;
			next_idx = '0;
			errors = 0;
			checked = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [15:0] value);
			case (idx)
				CFG_DURATION: duration_reg = value;
				CFG_MAX_BUF:  max_buf_reg = value[7:0];
				CFG_RETRY:    retry_reg = value;
				CFG_GIVE_UP:  give_up_reg = value;
				default: ;
			endcase
		endfunction

		// a register holding zero behaves as its default
		function logic [15:0] duration_ms();
			return duration_reg == '0 ? DFLT_DURATION : duration_reg;
		endfunction

		function logic [7:0] max_buf();
			return max_buf_reg == '0 ? DFLT_MAX_BUF : max_buf_reg;
		endfunction

		function logic [15:0] retry_ms();
			return retry_reg == '0 ? DFLT_RETRY : retry_reg;
		endfunction

		function logic [15:0] give_up_ms();
			return give_up_reg == '0 ? DFLT_GIVE_UP : give_up_reg;
		endfunction

		// elapsed time read as signed, a negative one never runs past a limit
		function bit runs_past(logic [31:0] now, logic [31:0] since, logic [15:0] limit);
			logic [31:0] d;
			d = now - since;
			return !d[31] && d > {16'd0, limit};
		endfunction

		function logic signed [16:0] put_delay(logic [31:0] now);
			logic [31:0] lag, dur, rest;
			dur = {16'd0, duration_ms()};
			if (state != LINK_OPEN)
				return -17'sd1;
			if (no_frame)
				return '0;
			lag = now - frame_stamp;
			if (lag > dur)
				return '0;
			rest = dur - lag;
			return {1'b0, rest[15:0]};
		endfunction

		function logic [15:0] frames_ready(logic [31:0] now);
			logic [31:0] lag, quot;
			if (state != LINK_OPEN)
				return '0;
			if (no_frame)
				return {8'd0, max_buf()};
			lag = now - frame_stamp;
			if (lag[31])
				return '0;
			quot = lag / {16'd0, duration_ms()};
			return quot > 32'd65535 ? 16'hFFFF : quot[15:0];
		endfunction

		// advance the session by one accepted transfer and queue its result
		function void note_item(link_item_t it);
			link_result_t r;
			logic [31:0] dur;
			r = '0;
			r.frame_index = next_idx;
			dur = {16'd0, duration_ms()};
			case (it.op)
				OP_START: begin
					state = LINK_WAITING;
					fault = ERR_NONE;
					next_idx = '0;
					no_frame = 1'b1;
					frame_stamp = '0;
					if (it.resolve_ok) begin
						first_req = it.now;
						last_req = it.now;
						r.send_borrow = 1'b1;
					end else begin
						state = LINK_ERROR;
						fault = ERR_UNRESOLVED;
					end
				end
				OP_POLL: begin
					if (state == LINK_WAITING) begin
						if (runs_past(it.now, first_req, give_up_ms())) begin
							state = LINK_ERROR;
							fault = ERR_TIMEOUT;
						end else if (runs_past(it.now, last_req, retry_ms())) begin
							last_req = it.now;
							r.send_borrow = 1'b1;
						end
					end
				end
				OP_MSG: begin
					if (it.msg_kind == MSG_LENT) begin
						state = LINK_OPEN;
						no_frame = 1'b1;
					end else if (it.msg_kind == MSG_FAIL) begin
						state = LINK_ERROR;
						fault = {1'b0, it.fail_reason} + 3'd1;
					end else begin
						state = LINK_ERROR;
						fault = ERR_MALFORMED;
					end
				end
				OP_PUT: begin
					// the wait on a put is taken before the frame clock moves
					r.wait_ms = put_delay(it.now);
					if (state == LINK_OPEN && it.send_ok) begin
						r.put_accepted = 1'b1;
						next_idx = next_idx + 8'd1;
						if (no_frame) begin
							frame_stamp = it.now - ({24'd0, max_buf()} - 32'd1) * dur;
							no_frame = 1'b0;
						end else begin
							frame_stamp = frame_stamp + dur;
						end
					end
				end
				default: ;
			endcase
			if (it.op != OP_PUT) begin
				r.wait_ms = put_delay(it.now);
				r.frame_index = next_idx;
			end
			r.link_state = state;
			r.error_code = state == LINK_ERROR ? fault : ERR_NONE;
			r.ready_count = frames_ready(it.now);
			due_results.push_back(r);
		endfunction

		task report(string what, int got, int want);
			errors++;
			if (errors <= 100)
				$display("result %0d: %s is %0d, expected %0d", checked, what, got, want);
		endtask

		task check_result(link_result_t got);
			link_result_t want;
			checked++;
			if (due_results.size() == 0) begin
				report("result with nothing pending, link_state", got.link_state, 0);
				return;
			end
			want = due_results.pop_front();
			if (got.link_state !== want.link_state)
				report("link_state", got.link_state, want.link_state);
			if (got.error_code !== want.error_code)
				report("error_code", got.error_code, want.error_code);
			if (got.send_borrow !== want.send_borrow)
				report("send_borrow", got.send_borrow, want.send_borrow);
			if (got.put_accepted !== want.put_accepted)
				report("put_accepted", got.put_accepted, want.put_accepted);
			if (got.frame_index !== want.frame_index)
				report("frame_index", got.frame_index, want.frame_index);
			if (got.ready_count !== want.ready_count)
				report("ready_count", got.ready_count, want.ready_count);
			if (got.wait_ms !== want.wait_ms)
				report("wait_ms", got.wait_ms, want.wait_ms);
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [1:0]         cfg_index;
	logic [15:0]        cfg_wdata;
	logic               in_valid;
	logic               in_stall;
	logic [2:0]         operation;
	logic [31:0]        now_ms;
	logic               resolve_ok;
	logic [1:0]         msg_kind;
	logic [1:0]         fail_reason;
	logic               send_ok;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         link_state;
	logic [2:0]         error_code;
	logic               send_borrow;
	logic               put_accepted;
	logic [7:0]         frame_index;
	logic [15:0]        ready_count;
	logic signed [16:0] wait_ms;

	link_session_scoreboard sb;
	link_result_t result_seen;
	logic [31:0] clock_ms;
	int items_sent;
	int cycles;
	int send_idle_pct;
	int stall_pct;
	int hold_left;
	bit want_hold;

	frame_link_session_controller uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.now_ms       (now_ms),
		.resolve_ok   (resolve_ok),
		.msg_kind     (msg_kind),
		.fail_reason  (fail_reason),
		.send_ok      (send_ok),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.link_state   (link_state),
		.error_code   (error_code),
		.send_borrow  (send_borrow),
		.put_accepted (put_accepted),
		.frame_index  (frame_index),
		.ready_count  (ready_count),
		.wait_ms      (wait_ms)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog, a hung handshake ends the run here
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_frame_link_session_controller: FAIL");
			$finish;
		end
	end

	// result side: values read here are the ones present before the edge,
	// so a transfer is exactly out_valid high with out_stall low
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			result_seen.link_state = link_t'(link_state);
			result_seen.error_code = error_code;
			result_seen.send_borrow = send_borrow;
			result_seen.put_accepted = put_accepted;
			result_seen.frame_index = frame_index;
			result_seen.ready_count = ready_count;
			result_seen.wait_ms = wait_ms;
			sb.check_result(result_seen);
		end
		// long hold-off, counted here so the sender keeps pushing meanwhile
		if (hold_left == 0 && want_hold) begin
			hold_left = HOLD_CYCLES;
			want_hold = 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
		end
		out_stall <= hold_left > 0 || (stall_pct > 0 && $urandom_range(0, 99) < stall_pct);
	end

	// one input transfer, payload held steady until the block takes it
	task automatic send_item(input link_item_t it);
		int gap;
		gap = 0;
		// gaps of varied length, inserted before a transfer is driven
		if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
			gap = $urandom_range(1, MAX_GAP);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= it.op;
		now_ms <= it.now;
		resolve_ok <= it.resolve_ok;
		msg_kind <= it.msg_kind;
		fail_reason <= it.fail_reason;
		send_ok <= it.send_ok;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_item(it);
		items_sent++;
	endtask

	task automatic drive(input logic [2:0] op, input logic [31:0] at_ms, input logic resolve,
			input logic [1:0] kind, input logic [1:0] reason, input logic ok);
		link_item_t it;
		it.op = op;
		it.now = at_ms;
		it.resolve_ok = resolve;
		it.msg_kind = kind;
		it.fail_reason = reason;
		it.send_ok = ok;
		send_item(it);
	endtask

	// every field random, stamped with the running clock
	function automatic link_item_t noise_item();
		link_item_t it;
		it.op = 3'($urandom_range(0, 7));
		it.now = clock_ms;
		it.resolve_ok = 1'($urandom_range(0, 1));
		it.msg_kind = 2'($urandom_range(0, 3));
		it.fail_reason = 2'($urandom_range(0, 3));
		it.send_ok = 1'($urandom_range(0, 1));
		return it;
	endfunction

	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.due_results.size() != 0)
			@(posedge clk);
	endtask

	// writes all four registers back to back with the enable held high
	task automatic set_config(input logic [15:0] dur, input logic [7:0] depth,
			input logic [15:0] retry, input logic [15:0] give_up);
		logic [15:0] depth_word;
		depth_word = {8'($urandom_range(0, 255)), depth};
		cfg_we <= 1'b1;
		cfg_index <= CFG_DURATION;
		cfg_wdata <= dur;
		@(posedge clk);
		cfg_index <= CFG_MAX_BUF;
		cfg_wdata <= depth_word;
		@(posedge clk);
		cfg_index <= CFG_RETRY;
		cfg_wdata <= retry;
		@(posedge clk);
		cfg_index <= CFG_GIVE_UP;
		cfg_wdata <= give_up;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(CFG_DURATION, dur);
		sb.write_reg(CFG_MAX_BUF, depth_word);
		sb.write_reg(CFG_RETRY, retry);
		sb.write_reg(CFG_GIVE_UP, give_up);
	endtask

	// one session: start, some polls, a sink reply, then puts and queries,
	// with stray transfers mixed in
	task automatic run_session();
		link_item_t it;
		logic [31:0] t0;
		int polls, puts, k, pick;
		case ($urandom_range(0, 3))
			0: clock_ms = $urandom();
			1: clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
			default: clock_ms = clock_ms + $urandom_range(0, 5000);
		endcase
		t0 = clock_ms;
		it = noise_item();
		it.op = OP_START;
		it.resolve_ok = $urandom_range(0, 9) != 0;
		send_item(it);

		polls = $urandom_range(0, 6);
		for (k = 0; k < polls; k++) begin
			case ($urandom_range(0, 9))
				0: clock_ms = clock_ms - $urandom_range(1, 50);
				// right around the give-up limit
				1: clock_ms = t0 + sb.give_up_ms() + $urandom_range(0, 2) - 1;
				default: clock_ms = clock_ms + $urandom_range(0, int'(sb.retry_ms()) + 2);
			endcase
			it = noise_item();
			if ($urandom_range(0, 9) != 0)
				it.op = OP_POLL;
			send_item(it);
		end

		clock_ms = clock_ms + $urandom_range(0, 20);
		it = noise_item();
		it.op = OP_MSG;
		case ($urandom_range(0, 9))
			8: it.msg_kind = MSG_FAIL;
			9: it.msg_kind = 2'($urandom_range(MSG_JUNK_LO, MSG_JUNK_HI));
			default: it.msg_kind = MSG_LENT;
		endcase
		send_item(it);

		// now and then a long run of 300 transfers, else a short one
		puts = $urandom_range(0, 99) < 3 ? 300 : $urandom_range(2, 40);
		for (k = 0; k < puts; k++) begin
			case ($urandom_range(0, 19))
				0: clock_ms = clock_ms + $urandom_range(0, 200000);
				1: clock_ms = clock_ms + $urandom();
				default: clock_ms = clock_ms + $urandom_range(0, 2 * int'(sb.duration_ms()));
			endcase
			it = noise_item();
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				it.op = OP_PUT;
				it.send_ok = $urandom_range(0, 9) != 0;
			end else if (pick < 9) begin
				it.op = OP_QUERY;
			end
			send_item(it);
		end
	endtask

	initial begin
		int phase, stop;
		logic [15:0] dur, retry, give_up;
		logic [7:0] depth;
		idle_mode_t mode;

		sb = new();
		items_sent = 0;
		cycles = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_left = 0;
		want_hold = 1'b0;
		clock_ms = '0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_DURATION;
		cfg_wdata <= '0;
		in_valid <= 1'b0;
		operation <= OP_QUERY;
		now_ms <= '0;
		resolve_ok <= 1'b0;
		msg_kind <= MSG_LENT;
		fail_reason <= '0;
		send_ok <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, on reset register values
		drive(OP_START, 32'd0, 1'b0, MSG_LENT, 2'd0, 1'b0);     // unresolved sink
		drive(OP_PUT, 32'd5, 1'b0, MSG_LENT, 2'd0, 1'b1);       // put while in error
		drive(OP_START, 32'd1000, 1'b1, MSG_LENT, 2'd0, 1'b0);
		drive(OP_POLL, 32'd1005, 1'b0, MSG_LENT, 2'd0, 1'b0);   // too early to retry
		drive(OP_POLL, 32'd1011, 1'b0, MSG_LENT, 2'd0, 1'b0);   // retry
		drive(OP_POLL, 32'd990, 1'b0, MSG_LENT, 2'd0, 1'b0);    // time went backward
		drive(OP_POLL, 32'd1500, 1'b0, MSG_LENT, 2'd0, 1'b0);   // at give-up, not past it
		drive(OP_POLL, 32'd1501, 1'b0, MSG_LENT, 2'd0, 1'b0);   // timed out
		drive(OP_START, 32'hFFFF_FFF0, 1'b1, MSG_LENT, 2'd0, 1'b0);
		drive(OP_POLL, 32'h0000_0005, 1'b0, MSG_LENT, 2'd0, 1'b0); // retry across wrap
		drive(OP_MSG, 32'd6, 1'b0, MSG_LENT, 2'd0, 1'b0);
		drive(OP_QUERY, 32'd7, 1'b0, MSG_LENT, 2'd0, 1'b0);     // open, nothing sent yet
		drive(OP_PUT, 32'd8, 1'b1, MSG_LENT, 2'd0, 1'b0);       // send failed
		drive(OP_PUT, 32'd8, 1'b0, MSG_LENT, 2'd0, 1'b1);       // first frame backdates
		drive(OP_PUT, 32'd9, 1'b0, MSG_LENT, 2'd0, 1'b1);
		drive(OP_QUERY, 32'h7FFF_0000, 1'b0, MSG_LENT, 2'd0, 1'b0); // saturated count
		drive(OP_POLL, 32'd20, 1'b0, MSG_LENT, 2'd0, 1'b0);     // poll while open
		drive(OP_SPARE_LO, 32'd21, 1'b0, MSG_FAIL, 2'd1, 1'b1);
		drive(OP_SPARE_HI, 32'd21, 1'b1, MSG_JUNK_HI, 2'd3, 1'b1);
		drive(OP_MSG, 32'd22, 1'b0, MSG_FAIL, 2'd0, 1'b0);
		drive(OP_MSG, 32'd23, 1'b0, MSG_FAIL, 2'd1, 1'b0);
		drive(OP_MSG, 32'd24, 1'b0, MSG_FAIL, 2'd2, 1'b0);
		drive(OP_MSG, 32'd25, 1'b0, MSG_FAIL, 2'd3, 1'b0);
		drive(OP_MSG, 32'd26, 1'b0, MSG_JUNK_LO, 2'd0, 1'b0);
		drive(OP_MSG, 32'd27, 1'b0, MSG_JUNK_HI, 2'd0, 1'b0);
		drive(OP_MSG, 32'd28, 1'b0, MSG_LENT, 2'd0, 1'b0);      // lent out of error
		drive(OP_PUT, 32'hFFFF_FFFF, 1'b0, MSG_LENT, 2'd0, 1'b1);

		for (phase = 0; phase < 8; phase++) begin
			drain_results();
			case (phase)
				0: set_config(16'd1, 8'd1, 16'd1, 16'd1);
				1: set_config(16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF);
				2: set_config(16'd0, 8'd0, 16'd0, 16'd0);  // zeros fall back to defaults
				default: begin
					dur = $urandom_range(0, 3) == 0 ? 16'hFFFF : 16'($urandom_range(1, 300));
					depth = 8'($urandom_range(1, 255));
					retry = 16'($urandom_range(1, 100));
					give_up = 16'($urandom_range(1, 2000));
					set_config(dur, depth, retry, give_up);
				end
			endcase
			mode = idle_mode_t'(phase % 4);
			case (mode)
				IDLE_SENDER: begin
					send_idle_pct = 61;
					stall_pct = 0;
				end
				IDLE_RECEIVER: begin
					send_idle_pct = 0;
					stall_pct = 61;
				end
				IDLE_BOTH: begin
					send_idle_pct = 28;
					stall_pct = 28;
				end
				default: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
			endcase
			// back-pressure run: receiver holds off while the sender keeps offering items
			if (phase == 4)
				want_hold = 1'b1;
			stop = items_sent + 150;
			while (items_sent < stop)
				run_session();
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.due_results.size() == 0)
			$display("tb_frame_link_session_controller: PASS");
		else
			$display("tb_frame_link_session_controller: FAIL");
		$finish;
	end

endmodule
